@@ hw/rtl/psa_pkg.sv @@
// shared widths, codes and payload types of the page span allocator
`default_nettype none
package psa_pkg;

	localparam int OP_W      = 2;
	localparam int LEN_W     = 23;
	localparam int ADDR_W    = 64;
	localparam int HPG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 64;

	localparam int DEF_NUM_PAGES   = 1024;
	localparam int DEF_PAGE_BYTES  = 4096;
	localparam int DEF_NUM_BUCKETS = 32;

	localparam logic [HPG_W-1:0] HEAP_PAGES_RST = HPG_W'(1024);

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_PAGES = 2'd1;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [LEN_W-1:0]  length_bytes;
		logic [ADDR_W-1:0] buffer_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              ok;
		logic [LEN_W-1:0]  granted_bytes;
	} rsp_t;

endpackage
`default_nettype wire

@@ hw/rtl/psa_ifs.sv @@
// request, response and configuration channel interfaces
`default_nettype none
interface psa_req_if;
	logic                        valid;
	logic                        ready;
	logic [psa_pkg::OP_W-1:0]    op;
	logic [psa_pkg::LEN_W-1:0]   length_bytes;
	logic [psa_pkg::ADDR_W-1:0]  buffer_address;
	modport source(output valid, op, length_bytes, buffer_address, input ready);
	modport sink(input valid, op, length_bytes, buffer_address, output ready);
endinterface

interface psa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [psa_pkg::ADDR_W-1:0]  address;
	logic                        ok;
	logic [psa_pkg::LEN_W-1:0]   granted_bytes;
	modport source(output valid, address, ok, granted_bytes, input ready);
	modport sink(input valid, address, ok, granted_bytes, output ready);
endinterface

interface psa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [psa_pkg::CFG_IDX_W-1:0]  index;
	logic [psa_pkg::CFG_DAT_W-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/page_span_allocator.sv @@
// top level of the page span allocator: configuration registers, request intake, response register
// Each transaction's length depends on the sequencer, which walks the span record memory one
// record at a time. An alloc scans buckets in turn and passes over records until a span fits,
// then reinserts any remainder; a free checks both neighbors and, for each merged neighbor,
// passes over records while unlinking it. An init sweeps the boundary map one entry a cycle. A
// refused or unknown request goes straight to the done state. The engine is ready again as soon
// as its result moves to the response register. After reset the same sweep runs over the whole
// boundary map before the first request is taken; configuration writes are taken at any time.
// PAGE_BYTES must be a power of two. A new request is taken while a response still waits.
`default_nettype none
module page_span_allocator #(
	parameter int NUM_PAGES   = psa_pkg::DEF_NUM_PAGES,
	parameter int PAGE_BYTES  = psa_pkg::DEF_PAGE_BYTES,
	parameter int NUM_BUCKETS = psa_pkg::DEF_NUM_BUCKETS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	psa_req_if.sink    req,
	psa_rsp_if.source  rsp,
	psa_cfg_if.sink    cfg
);

	logic [psa_pkg::ADDR_W-1:0] heap_base_q;
	logic [psa_pkg::HPG_W-1:0]  heap_pages_q;
	logic                       out_vld_q;
	psa_pkg::rsp_t              out_q;
	psa_pkg::req_t              req_w;
	psa_pkg::rsp_t              core_rsp;
	logic                       core_ready, core_done, core_take;

	assign req_w = '{op: req.op, length_bytes: req.length_bytes,
		buffer_address: req.buffer_address};
	assign req.ready = core_ready;
	assign cfg.ready = 1'b1;
	assign core_take = core_done && (!out_vld_q || rsp.ready);

	psa_core #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES),
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req.valid && core_ready),
		.req       (req_w),
		.heap_base (heap_base_q),
		.heap_pages(heap_pages_q),
		.ready     (core_ready),
		.done      (core_done),
		.take      (core_take),
		.rsp       (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= '0;
			heap_pages_q <= psa_pkg::HEAP_PAGES_RST;
		end else if (cfg.valid) begin
			if (cfg.index == psa_pkg::CFG_HEAP_BASE)
				heap_base_q <= cfg.data;
			else if (cfg.index == psa_pkg::CFG_HEAP_PAGES)
				heap_pages_q <= cfg.data[psa_pkg::HPG_W-1:0];
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (core_take) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_take)
			out_q <= core_rsp;
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.address       = out_q.address;
	assign rsp.ok            = out_q.ok;
	assign rsp.granted_bytes = out_q.granted_bytes;

endmodule
`default_nettype wire

@@ hw/rtl/psa_core.sv @@
// span bookkeeping engine: record, boundary, spare and bucket memories with sequencer
`default_nettype none
module psa_core #(
	parameter int NUM_PAGES   = psa_pkg::DEF_NUM_PAGES,
	parameter int PAGE_BYTES  = psa_pkg::DEF_PAGE_BYTES,
	parameter int NUM_BUCKETS = psa_pkg::DEF_NUM_BUCKETS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire psa_pkg::req_t               req,
	input  wire logic [psa_pkg::ADDR_W-1:0]  heap_base,
	input  wire logic [psa_pkg::HPG_W-1:0]   heap_pages,
	output logic                             ready,
	output logic                             done,
	input  wire logic                        take,
	output psa_pkg::rsp_t                    rsp
);

	localparam int IW  = $clog2(NUM_PAGES);
	localparam int CW  = $clog2(NUM_PAGES + 1);
	localparam int BW  = $clog2(NUM_BUCKETS);
	localparam int PSH = $clog2(PAGE_BYTES);
	localparam int PGW = psa_pkg::LEN_W + 1;
	localparam logic [CW-1:0] NO_SPAN = CW'(NUM_PAGES);
	localparam logic [BW-1:0] LAST_B  = BW'(NUM_BUCKETS - 1);

	typedef struct packed {
		logic          live;
		logic [CW-1:0] nxt;
		logic [CW-1:0] len;
		logic [IW-1:0] start;
	} rec_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DONE,
		S_AL_HEAD, S_AL_HEADW, S_AL_CHK, S_AL_REC, S_AL_UNLINK, S_AL_KILL,
		S_AL_CLR, S_AL_CLR2,
		S_MK_POP, S_MK_WR, S_MK_BND2,
		S_FR_B, S_FR_B1, S_FR_B2, S_FR_A, S_FR_A1, S_FR_A2, S_FR_DEC,
		S_FR_AFT, S_FR_MK,
		S_DR_HEAD, S_DR_HEADW, S_DR_CHK, S_DR_REC, S_DR_KILL
	} state_t;

	function automatic logic [BW-1:0] bucket_for(input logic [CW-1:0] len);
		logic [BW-1:0] b;
		if (len == '0)
			b = '0;
		else if (32'(len) >= NUM_BUCKETS)
			b = LAST_B;
		else
			b = BW'(len - 1'b1);
		return b;
	endfunction

	// memories
	rec_t          rec_mem [NUM_PAGES];
	logic [CW-1:0] bnd_mem [NUM_PAGES];
	logic [IW-1:0] spr_mem [NUM_PAGES];
	logic [CW-1:0] hd_mem  [NUM_BUCKETS];
	logic          hd_vld_q [NUM_BUCKETS];

	rec_t          rec_rdata_q;
	logic [CW-1:0] bnd_rdata_q;
	logic [IW-1:0] spr_rdata_q;
	logic [CW-1:0] hd_rdata_q;
	logic          hd_rvld_q;

	logic [IW-1:0] rec_raddr, rec_waddr, bnd_raddr, bnd_waddr, spr_raddr, spr_waddr;
	logic [BW-1:0] hd_raddr, hd_waddr;
	logic          rec_we, bnd_we, spr_we, hd_we, hd_clr;
	rec_t          rec_wdata;
	logic [CW-1:0] bnd_wdata, hd_wdata;
	logic [IW-1:0] spr_wdata;

	// sequencer registers
	state_t        state_q, ret_q;
	logic          init_q, synth_q;
	logic [IW-1:0] sweep_q;
	logic [CW-1:0] count_q, lw_q;
	logic [CW-1:0] pages_q, pend_q, cur_q, prev_q, guard_q, tgt_q, tgt_len_q, tgt_nxt_q;
	logic [IW-1:0] pstart_q, tgt_start_q, mk_start_q, ms_q, id_q, bstart_q, astart_q;
	logic [CW-1:0] mk_len_q, me_q, before_q, after_q, tmp_id_q, blen_q, alen_q;
	logic [BW-1:0] b_q;
	rec_t          prev_rec_q;
	psa_pkg::rsp_t res_q;

	// request decode
	logic [PGW-1:0]             pages_w;
	logic [psa_pkg::ADDR_W-1:0] off_w, diff_w, alloc_addr_w, gr_w;
	logic [CW-1:0]              lim_w, head_w, bnd_id_w;
	logic [IW-1:0]              new_id_w;
	logic                       free_bad_w;

	always_comb begin
		pages_w = (req.length_bytes == '0) ? '0
			: PGW'((req.length_bytes - 1'b1) >> PSH) + PGW'(1);
		diff_w  = req.buffer_address - heap_base;
		off_w   = diff_w >> PSH;
		lim_w   = (32'(heap_pages) > NUM_PAGES) ? CW'(NUM_PAGES) : CW'(heap_pages);
		free_bad_w = (off_w >= 64'(lim_w))
			|| (32'(pages_w) > 32'(lim_w) - 32'(off_w[CW-1:0]));
		head_w  = hd_rvld_q ? hd_rdata_q : NO_SPAN;
		new_id_w = synth_q ? IW'(NUM_PAGES - 1) - count_q[IW-1:0] : spr_rdata_q;
		bnd_id_w = bnd_rdata_q - 1'b1;
		alloc_addr_w = heap_base + (64'(tgt_start_q) << PSH);
		gr_w = 64'(pages_q) << PSH;
	end

	// memory strobes
	always_comb begin
		rec_raddr = cur_q[IW-1:0];
		rec_we    = 1'b0;
		rec_waddr = tgt_q[IW-1:0];
		rec_wdata = '{live: 1'b0, nxt: NO_SPAN, len: tgt_len_q, start: tgt_start_q};
		bnd_raddr = pstart_q - 1'b1;
		bnd_we    = 1'b0;
		bnd_waddr = sweep_q;
		bnd_wdata = '0;
		spr_raddr = IW'(count_q - 1'b1);
		spr_we    = 1'b0;
		spr_waddr = count_q[IW-1:0];
		spr_wdata = tgt_q[IW-1:0];
		hd_raddr  = b_q;
		hd_we     = 1'b0;
		hd_waddr  = b_q;
		hd_wdata  = tgt_nxt_q;
		hd_clr    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				bnd_we = 1'b1;
				hd_clr = 1'b1;
			end
			S_AL_UNLINK: begin
				if (prev_q == NO_SPAN) begin
					hd_we = 1'b1;
				end else begin
					rec_we    = 1'b1;
					rec_waddr = prev_q[IW-1:0];
					rec_wdata = prev_rec_q;
					rec_wdata.nxt = tgt_nxt_q;
				end
			end
			S_AL_KILL, S_DR_KILL: begin
				rec_we = 1'b1;
				spr_we = (count_q < NO_SPAN);
			end
			S_AL_CLR: begin
				bnd_we    = 1'b1;
				bnd_waddr = tgt_start_q;
			end
			S_AL_CLR2: begin
				bnd_we    = 1'b1;
				bnd_waddr = IW'(32'(tgt_start_q) + 32'(pages_q) - 1);
			end
			S_MK_POP: begin
				hd_raddr = bucket_for(mk_len_q);
			end
			S_MK_WR: begin
				rec_we    = 1'b1;
				rec_waddr = new_id_w;
				rec_wdata = '{live: 1'b1, nxt: head_w, len: mk_len_q, start: mk_start_q};
				hd_we     = 1'b1;
				hd_waddr  = bucket_for(mk_len_q);
				hd_wdata  = CW'(new_id_w);
				bnd_we    = 1'b1;
				bnd_waddr = mk_start_q;
				bnd_wdata = CW'(new_id_w) + 1'b1;
			end
			S_MK_BND2: begin
				bnd_we    = 1'b1;
				bnd_waddr = IW'(32'(mk_start_q) + 32'(mk_len_q) - 1);
				bnd_wdata = CW'(id_q) + 1'b1;
			end
			S_FR_A: begin
				bnd_raddr = pend_q[IW-1:0];
			end
			S_FR_B1, S_FR_A1: begin
				rec_raddr = bnd_id_w[IW-1:0];
			end
			S_FR_DEC: begin
				bnd_we    = (before_q != NO_SPAN);
				bnd_waddr = pstart_q - 1'b1;
			end
			S_FR_AFT: begin
				bnd_we    = (after_q != NO_SPAN);
				bnd_waddr = pend_q[IW-1:0];
			end
			S_DR_HEAD: begin
				hd_raddr = bucket_for(tgt_len_q);
			end
			S_DR_REC: begin
				if (cur_q == tgt_q) begin
					if (prev_q == NO_SPAN) begin
						hd_we    = 1'b1;
						hd_wdata = rec_rdata_q.nxt;
					end else begin
						rec_we    = 1'b1;
						rec_waddr = prev_q[IW-1:0];
						rec_wdata = prev_rec_q;
						rec_wdata.nxt = rec_rdata_q.nxt;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rec_we)
			rec_mem[rec_waddr] <= rec_wdata;
		rec_rdata_q <= rec_mem[rec_raddr];
	end

	always_ff @(posedge clk) begin
		if (bnd_we)
			bnd_mem[bnd_waddr] <= bnd_wdata;
		bnd_rdata_q <= bnd_mem[bnd_raddr];
	end

	always_ff @(posedge clk) begin
		if (spr_we)
			spr_mem[spr_waddr] <= spr_wdata;
		spr_rdata_q <= spr_mem[spr_raddr];
	end

	always_ff @(posedge clk) begin
		if (hd_we)
			hd_mem[hd_waddr] <= hd_wdata;
		hd_rdata_q <= hd_mem[hd_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUCKETS; i++)
				hd_vld_q[i] <= 1'b0;
			hd_rvld_q <= 1'b0;
		end else begin
			hd_rvld_q <= hd_vld_q[hd_raddr];
			if (hd_clr) begin
				for (int i = 0; i < NUM_BUCKETS; i++)
					hd_vld_q[i] <= 1'b0;
			end else if (hd_we) begin
				hd_vld_q[hd_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q   <= S_IDLE;
			init_q  <= 1'b0;
			synth_q <= 1'b0;
			sweep_q <= '0;
			count_q <= NO_SPAN;
			lw_q    <= NO_SPAN;
		end else begin
			case (state_q)
				S_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == IW'(NUM_PAGES - 1)) begin
						init_q <= 1'b0;
						sweep_q <= '0;
						if (init_q && mk_len_q != '0) begin
							ret_q   <= S_DONE;
							state_q <= S_MK_POP;
						end else if (init_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (start) begin
						res_q <= '0;
						case (req.op)
							psa_pkg::OP_ALLOC: begin
								pages_q <= CW'(pages_w);
								b_q     <= bucket_for(CW'(pages_w));
								if (pages_w == '0 || 32'(pages_w) > NUM_PAGES)
									state_q <= S_DONE;
								else
									state_q <= S_AL_HEAD;
							end
							psa_pkg::OP_FREE: begin
								pages_q  <= CW'(pages_w);
								pstart_q <= off_w[IW-1:0];
								pend_q   <= CW'(32'(off_w[CW-1:0]) + 32'(pages_w));
								before_q <= NO_SPAN;
								after_q  <= NO_SPAN;
								if (pages_w == '0 || free_bad_w)
									state_q <= S_DONE;
								else
									state_q <= S_FR_B;
							end
							psa_pkg::OP_INIT: begin
								res_q.ok   <= 1'b1;
								count_q    <= NO_SPAN;
								lw_q       <= NO_SPAN;
								init_q     <= 1'b1;
								sweep_q    <= '0;
								mk_start_q <= '0;
								mk_len_q   <= lim_w;
								state_q    <= S_CLEAR;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_DONE: begin
					if (take)
						state_q <= S_IDLE;
				end
				S_AL_HEAD: begin
					prev_q  <= NO_SPAN;
					guard_q <= '0;
					state_q <= S_AL_HEADW;
				end
				S_AL_HEADW: begin
					cur_q   <= head_w;
					state_q <= S_AL_CHK;
				end
				S_AL_CHK: begin
					if (cur_q < NO_SPAN && guard_q < NO_SPAN) begin
						state_q <= S_AL_REC;
					end else if (b_q == LAST_B) begin
						state_q <= S_DONE;
					end else begin
						b_q     <= b_q + 1'b1;
						state_q <= S_AL_HEAD;
					end
				end
				S_AL_REC: begin
					if (rec_rdata_q.len >= pages_q) begin
						tgt_q       <= cur_q;
						tgt_start_q <= rec_rdata_q.start;
						tgt_len_q   <= rec_rdata_q.len;
						tgt_nxt_q   <= rec_rdata_q.nxt;
						state_q     <= S_AL_UNLINK;
					end else begin
						prev_q     <= cur_q;
						prev_rec_q <= rec_rdata_q;
						cur_q      <= rec_rdata_q.nxt;
						guard_q    <= guard_q + 1'b1;
						state_q    <= S_AL_CHK;
					end
				end
				S_AL_UNLINK: begin
					state_q <= S_AL_KILL;
				end
				S_AL_KILL: begin
					if (count_q < NO_SPAN)
						count_q <= count_q + 1'b1;
					res_q.ok            <= 1'b1;
					res_q.address       <= alloc_addr_w;
					res_q.granted_bytes <= gr_w[psa_pkg::LEN_W-1:0];
					if (tgt_len_q > pages_q) begin
						mk_start_q <= IW'(32'(tgt_start_q) + 32'(pages_q));
						mk_len_q   <= tgt_len_q - pages_q;
						ret_q      <= S_AL_CLR;
						state_q    <= S_MK_POP;
					end else begin
						state_q <= S_AL_CLR;
					end
				end
				S_AL_CLR: begin
					state_q <= S_AL_CLR2;
				end
				S_AL_CLR2: begin
					state_q <= S_DONE;
				end
				S_MK_POP: begin
					count_q <= count_q - 1'b1;
					synth_q <= (count_q - 1'b1) < lw_q;
					if ((count_q - 1'b1) < lw_q)
						lw_q <= count_q - 1'b1;
					state_q <= S_MK_WR;
				end
				S_MK_WR: begin
					id_q    <= new_id_w;
					state_q <= S_MK_BND2;
				end
				S_MK_BND2: begin
					state_q <= ret_q;
				end
				S_FR_B: begin
					state_q <= (pstart_q != '0) ? S_FR_B1 : S_FR_A;
				end
				S_FR_B1: begin
					tmp_id_q <= bnd_id_w;
					if (bnd_rdata_q != '0 && bnd_id_w < NO_SPAN)
						state_q <= S_FR_B2;
					else
						state_q <= S_FR_A;
				end
				S_FR_B2: begin
					if (rec_rdata_q.live
						&& 32'(rec_rdata_q.start) + 32'(rec_rdata_q.len) == 32'(pstart_q)) begin
						before_q <= tmp_id_q;
						bstart_q <= rec_rdata_q.start;
						blen_q   <= rec_rdata_q.len;
					end
					state_q <= S_FR_A;
				end
				S_FR_A: begin
					state_q <= (pend_q < lim_w) ? S_FR_A1 : S_FR_DEC;
				end
				S_FR_A1: begin
					tmp_id_q <= bnd_id_w;
					if (bnd_rdata_q != '0 && bnd_id_w < NO_SPAN)
						state_q <= S_FR_A2;
					else
						state_q <= S_FR_DEC;
				end
				S_FR_A2: begin
					if (rec_rdata_q.live && CW'(rec_rdata_q.start) == pend_q) begin
						after_q  <= tmp_id_q;
						astart_q <= rec_rdata_q.start;
						alen_q   <= rec_rdata_q.len;
					end
					state_q <= S_FR_DEC;
				end
				S_FR_DEC: begin
					if (before_q == NO_SPAN && after_q == NO_SPAN && count_q == '0) begin
						state_q <= S_DONE;
					end else begin
						res_q.ok <= 1'b1;
						me_q     <= pend_q;
						if (before_q != NO_SPAN) begin
							ms_q        <= bstart_q;
							tgt_q       <= before_q;
							tgt_start_q <= bstart_q;
							tgt_len_q   <= blen_q;
							ret_q       <= S_FR_AFT;
							state_q     <= S_DR_HEAD;
						end else begin
							ms_q    <= pstart_q;
							state_q <= S_FR_AFT;
						end
					end
				end
				S_FR_AFT: begin
					if (after_q != NO_SPAN) begin
						me_q        <= CW'(32'(astart_q) + 32'(alen_q));
						tgt_q       <= after_q;
						tgt_start_q <= astart_q;
						tgt_len_q   <= alen_q;
						ret_q       <= S_FR_MK;
						state_q     <= S_DR_HEAD;
					end else begin
						state_q <= S_FR_MK;
					end
				end
				S_FR_MK: begin
					mk_start_q <= ms_q;
					mk_len_q   <= me_q - CW'(ms_q);
					ret_q      <= S_DONE;
					state_q    <= S_MK_POP;
				end
				S_DR_HEAD: begin
					b_q     <= bucket_for(tgt_len_q);
					prev_q  <= NO_SPAN;
					guard_q <= '0;
					state_q <= S_DR_HEADW;
				end
				S_DR_HEADW: begin
					cur_q   <= head_w;
					state_q <= S_DR_CHK;
				end
				S_DR_CHK: begin
					if (cur_q < NO_SPAN && guard_q < NO_SPAN)
						state_q <= S_DR_REC;
					else
						state_q <= S_DR_KILL;
				end
				S_DR_REC: begin
					if (cur_q == tgt_q) begin
						state_q <= S_DR_KILL;
					end else begin
						prev_q     <= cur_q;
						prev_rec_q <= rec_rdata_q;
						cur_q      <= rec_rdata_q.nxt;
						guard_q    <= guard_q + 1'b1;
						state_q    <= S_DR_CHK;
					end
				end
				S_DR_KILL: begin
					if (count_q < NO_SPAN)
						count_q <= count_q + 1'b1;
					state_q <= ret_q;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign ready = (state_q == S_IDLE);
	assign done  = (state_q == S_DONE);
	assign rsp   = res_q;

endmodule
`default_nettype wire

@@ hw/rtl/psa_checker.sv @@
// port-level checks of the page span allocator and their binding
`default_nettype none
module psa_checker #(
	parameter int PAGE_BYTES = psa_pkg::DEF_PAGE_BYTES
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_ready,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic                        rsp_ok,
	input wire logic [psa_pkg::ADDR_W-1:0]  rsp_address,
	input wire logic [psa_pkg::LEN_W-1:0]   rsp_granted_bytes
);

	localparam logic [psa_pkg::LEN_W-1:0] PG_MASK = psa_pkg::LEN_W'(PAGE_BYTES - 1);

	// one transaction at a time in the engine
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while engine busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_address == '0 && rsp_granted_bytes == '0)
		else $error("failed response carries data");

	a_grant_pages: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_granted_bytes & PG_MASK) == '0)
		else $error("grant not whole pages");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address)
			&& $stable(rsp_ok) && $stable(rsp_granted_bytes))
		else $error("stalled response changed");

endmodule

bind page_span_allocator psa_checker #(.PAGE_BYTES(PAGE_BYTES)) u_psa_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_ok           (rsp.ok),
	.rsp_address      (rsp.address),
	.rsp_granted_bytes(rsp.granted_bytes)
);
`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for page_span_allocator: random and directed requests checked against a span predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	localparam int NP = psa_pkg::DEF_NUM_PAGES;
	localparam int PB = psa_pkg::DEF_PAGE_BYTES;
	localparam int NB = psa_pkg::DEF_NUM_BUCKETS;
	localparam int unsigned NONE = NP;
	localparam logic [psa_pkg::OP_W-1:0] OP_BAD = 2'd3;
	localparam int CYCLE_LIMIT = 10000000;

	typedef struct {
		logic [psa_pkg::ADDR_W-1:0] addr;
		int unsigned pages;
	} buffer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	psa_req_if req ();
	psa_rsp_if rsp ();
	psa_cfg_if cfg ();

	page_span_allocator uut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	always #6 clk = ~clk;

	// predictor state
	logic [63:0] heap_base;
	logic [10:0] heap_pages;
	int unsigned span_start [NP];
	int unsigned span_len [NP];
	int unsigned span_next [NP];
	bit span_live [NP];
	int unsigned bucket_head [NB];
	int unsigned edge_map [NP];
	int unsigned spare_ids [NP];
	int unsigned spare_cnt;

	psa_pkg::req_t pending_reqs [$];
	psa_pkg::rsp_t expected_rsps [$];
	buffer_t owned_bufs [$];
	int errors = 0;
	int cycles = 0;
	bit burst = 0;
	bit req_done = 0;

	task automatic report(string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	function automatic int unsigned bucket_of(int unsigned n);
		if (n == 0) return 0;
		if (n >= NB) return NB - 1;
		return n - 1;
	endfunction

	function automatic int unsigned pages_in_use();
		return (heap_pages > NP) ? NP : 32'(heap_pages);
	endfunction

	function automatic void clear_heap();
		for (int i = 0; i < NB; i++) bucket_head[i] = NONE;
		for (int i = 0; i < NP; i++) begin
			span_start[i] = 0;
			span_len[i] = 0;
			span_next[i] = NONE;
			span_live[i] = 0;
			edge_map[i] = 0;
			spare_ids[i] = NP - 1 - i;
		end
		spare_cnt = NP;
	endfunction

	function automatic void release_id(int unsigned id);
		span_live[id] = 0;
		span_next[id] = NONE;
		if (spare_cnt < NP) begin
			spare_ids[spare_cnt] = id;
			spare_cnt++;
		end
	endfunction

	function automatic void unlink_span(int unsigned id);
		int unsigned b, prev, cur, guard;
		b = bucket_of(span_len[id]);
		prev = NONE;
		cur = bucket_head[b];
		guard = 0;
		while (cur < NP && guard < NP) begin
			if (cur == id) begin
				if (prev == NONE) bucket_head[b] = span_next[cur];
				else span_next[prev] = span_next[cur];
				break;
			end
			prev = cur;
			cur = span_next[cur];
			guard++;
		end
		release_id(id);
	endfunction

	function automatic void add_span(int unsigned start, int unsigned len);
		int unsigned id, b;
		spare_cnt--;
		id = spare_ids[spare_cnt];
		b = bucket_of(len);
		span_start[id] = start;
		span_len[id] = len;
		span_live[id] = 1;
		span_next[id] = bucket_head[b];
		bucket_head[b] = id;
		edge_map[start] = id + 1;
		edge_map[start + len - 1] = id + 1;
	endfunction

	function automatic bit take_pages(int unsigned pages, output logic [63:0] addr);
		int unsigned prev, cur, guard, start, rest;
		addr = '0;
		if (pages > NP) return 0;
		for (int unsigned b = bucket_of(pages); b < NB; b++) begin
			prev = NONE;
			cur = bucket_head[b];
			guard = 0;
			while (cur < NP && guard < NP) begin
				if (span_len[cur] >= pages) begin
					start = span_start[cur];
					rest = span_len[cur] - pages;
					if (prev == NONE) bucket_head[b] = span_next[cur];
					else span_next[prev] = span_next[cur];
					release_id(cur);
					if (rest > 0) add_span(start + pages, rest);
					edge_map[start] = 0;
					edge_map[start + pages - 1] = 0;
					addr = heap_base + 64'(start) * 64'(PB);
					return 1;
				end
				prev = cur;
				cur = span_next[cur];
				guard++;
			end
		end
		return 0;
	endfunction

	function automatic bit return_pages(logic [63:0] buf_addr, int unsigned pages);
		logic [63:0] pst64;
		int unsigned lim, pst, pend, e, lo_id, hi_id, m_start, m_end;
		lim = pages_in_use();
		pst64 = (buf_addr - heap_base) / 64'(PB);
		if (pst64 >= 64'(lim) || 64'(pages) > 64'(lim) - pst64) return 0;
		pst = 32'(pst64);
		pend = pst + pages;
		lo_id = NONE;
		hi_id = NONE;
		if (pst > 0) begin
			e = edge_map[pst - 1];
			if (e != 0 && span_live[e - 1] && span_start[e - 1] + span_len[e - 1] == pst)
				lo_id = e - 1;
		end
		if (pend < lim) begin
			e = edge_map[pend];
			if (e != 0 && span_live[e - 1] && span_start[e - 1] == pend) hi_id = e - 1;
		end
		if (lo_id == NONE && hi_id == NONE && spare_cnt == 0) return 0;
		m_start = pst;
		m_end = pend;
		if (lo_id != NONE) begin
			m_start = span_start[lo_id];
			edge_map[pst - 1] = 0;
			unlink_span(lo_id);
		end
		if (hi_id != NONE) begin
			m_end = span_start[hi_id] + span_len[hi_id];
			edge_map[pend] = 0;
			unlink_span(hi_id);
		end
		add_span(m_start, m_end - m_start);
		return 1;
	endfunction

	function automatic psa_pkg::rsp_t predict_rsp(psa_pkg::req_t r);
		psa_pkg::rsp_t o;
		int unsigned pages, n;
		logic [63:0] a;
		buffer_t bf;
		pages = (r.length_bytes == 0) ? 0 : (int'(r.length_bytes) - 1) / PB + 1;
		o = '0;
		case (r.op)
			psa_pkg::OP_ALLOC: begin
				if (pages > 0 && take_pages(pages, a)) begin
					o.address = a;
					o.ok = 1'b1;
					o.granted_bytes = psa_pkg::LEN_W'(pages * PB);
					bf.addr = a;
					bf.pages = pages;
					owned_bufs.push_back(bf);
				end
			end
			psa_pkg::OP_FREE: o.ok = pages > 0 && return_pages(r.buffer_address, pages);
			psa_pkg::OP_INIT: begin
				n = pages_in_use();
				clear_heap();
				if (n > 0) add_span(0, n);
				owned_bufs.delete();
				o.ok = 1'b1;
			end
			default: o.ok = 1'b0;
		endcase
		return o;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin : drv
		int gap;
		int unsigned g;
		bit nv;
		psa_pkg::req_t r;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.op <= psa_pkg::OP_ALLOC;
			req.length_bytes <= '0;
			req.buffer_address <= '0;
			gap = 0;
		end else begin
			nv = req.valid && !req.ready;
			if (req.valid && req.ready) begin
				r.op = req.op;
				r.length_bytes = req.length_bytes;
				r.buffer_address = req.buffer_address;
				expected_rsps.push_back(predict_rsp(r));
				g = burst ? 0 : $urandom_range(0, 10);
				gap = g;
			end
			if (!nv) begin
				if (gap > 0) gap--;
				else if (pending_reqs.size() > 0) begin
					r = pending_reqs.pop_front();
					req.op <= r.op;
					req.length_bytes <= r.length_bytes;
					req.buffer_address <= r.buffer_address;
					nv = 1;
				end
			end
			req.valid <= nv;
		end
	end

	// response sink with random stalls
	always @(posedge clk or negedge arst_n) begin : snk
		int s;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			s = 0;
		end else begin
			if (rsp.valid && rsp.ready) s = burst ? 0 : $urandom_range(0, 10);
			else if (s > 0) s--;
			rsp.ready <= (s == 0);
		end
	end

	// response monitor
	always @(posedge clk) begin : mon
		psa_pkg::rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsps.size() == 0) report("response with no request outstanding");
			else begin
				want = expected_rsps.pop_front();
				if (rsp.address !== want.address)
					report($sformatf("address %h, want %h", rsp.address, want.address));
				if (rsp.ok !== want.ok) report($sformatf("ok %b, want %b", rsp.ok, want.ok));
				if (rsp.granted_bytes !== want.granted_bytes)
					report($sformatf("granted_bytes %0d, want %0d",
						rsp.granted_bytes, want.granted_bytes));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d responses outstanding", expected_rsps.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send(logic [psa_pkg::OP_W-1:0] op, logic [psa_pkg::LEN_W-1:0] len,
		logic [63:0] ba);
		psa_pkg::req_t r;
		while (pending_reqs.size() > 0 || req.valid) @(negedge clk);
		r.op = op;
		r.length_bytes = len;
		r.buffer_address = ba;
		pending_reqs.push_back(r);
		@(negedge clk);
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [psa_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == psa_pkg::CFG_HEAP_BASE) heap_base = val;
		else heap_pages = val[10:0];
	endtask

	function automatic logic [psa_pkg::LEN_W-1:0] len_for(int unsigned pages);
		return psa_pkg::LEN_W'(pages * PB - $urandom_range(0, PB - 1));
	endfunction

	function automatic int unsigned pick_pages();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 70) return $urandom_range(1, 8);
		if (p < 95) return $urandom_range(9, 64);
		return $urandom_range(65, NP);
	endfunction

	task automatic random_items(int count);
		int unsigned p, k;
		buffer_t bf;
		logic [63:0] ba;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 39) drain();
			p = $urandom_range(0, 99);
			if (p < 45) send(psa_pkg::OP_ALLOC, len_for(pick_pages()), {$urandom, $urandom});
			else if (p < 85 && owned_bufs.size() > 0) begin
				k = $urandom_range(0, owned_bufs.size() - 1);
				bf = owned_bufs[k];
				owned_bufs.delete(k);
				send(psa_pkg::OP_FREE, len_for(bf.pages),
					bf.addr + 64'($urandom_range(0, PB - 1)));
			end else if (p < 93) begin
				ba = heap_base + 64'($urandom_range(0, NP + 4)) * 64'(PB)
					+ 64'($urandom_range(0, PB - 1));
				send(psa_pkg::OP_FREE, len_for($urandom_range(1, 16)), ba);
			end else if (p < 96)
				send(psa_pkg::OP_FREE, psa_pkg::LEN_W'($urandom), {$urandom, $urandom});
			else if (p < 98) send(OP_BAD, psa_pkg::LEN_W'($urandom), {$urandom, $urandom});
			else if (p < 99) send(psa_pkg::OP_ALLOC, '0, {$urandom, $urandom});
			else send(psa_pkg::OP_INIT, psa_pkg::LEN_W'($urandom), {$urandom, $urandom});
		end
	endtask

	initial begin
		heap_base = '0;
		heap_pages = psa_pkg::HEAP_PAGES_RST;
		clear_heap();
		cfg.valid <= 1'b0;
		cfg.index <= psa_pkg::CFG_HEAP_BASE;
		cfg.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: before init, zero length, unknown op, then an initialised heap
		send(psa_pkg::OP_ALLOC, 23'd1, '0);
		send(psa_pkg::OP_ALLOC, '0, '0);
		send(psa_pkg::OP_FREE, '0, '0);
		send(OP_BAD, '1, '1);
		send(psa_pkg::OP_FREE, psa_pkg::LEN_W'(PB), 64'(5 * PB));
		send(psa_pkg::OP_INIT, '0, '0);
		send(psa_pkg::OP_ALLOC, 23'd1, '1);
		send(psa_pkg::OP_ALLOC, psa_pkg::LEN_W'(PB), '0);
		send(psa_pkg::OP_ALLOC, psa_pkg::LEN_W'(PB + 1), '0);
		send(psa_pkg::OP_ALLOC, '1, '0);
		send(psa_pkg::OP_ALLOC, 23'(NP * PB), '0);
		send(psa_pkg::OP_FREE, 23'(PB), 64'(PB) + 64'(PB - 1));
		send(psa_pkg::OP_FREE, 23'(PB), 64'(PB));
		send(psa_pkg::OP_FREE, 23'(2 * PB), '0);
		send(psa_pkg::OP_FREE, 23'(PB), '1);
		send(psa_pkg::OP_FREE, 23'(2 * PB), 64'((NP - 1) * PB));
		send(psa_pkg::OP_FREE, '1, '0);
		send(psa_pkg::OP_INIT, '1, '1);
		send(psa_pkg::OP_ALLOC, 23'(NP * PB), '0);
		send(psa_pkg::OP_FREE, 23'(NP * PB), '0);
		send(psa_pkg::OP_ALLOC, 23'(40 * PB), '0);
		send(psa_pkg::OP_ALLOC, 23'(31 * PB), '0);
		drain();

		burst = 1;
		random_items(60);
		burst = 0;
		random_items(100);
		drain();

		write_reg(psa_pkg::CFG_HEAP_BASE, {$urandom, $urandom});
		write_reg(psa_pkg::CFG_HEAP_PAGES, 64'h7FF);
		random_items(20);
		send(psa_pkg::OP_INIT, 23'd1, '0);
		random_items(110);
		drain();

		write_reg(psa_pkg::CFG_HEAP_BASE, '1);
		write_reg(psa_pkg::CFG_HEAP_PAGES, 64'd1);
		send(psa_pkg::OP_INIT, 23'd1, '0);
		send(psa_pkg::OP_ALLOC, 23'd1, '0);
		send(psa_pkg::OP_ALLOC, 23'd1, '0);
		send(psa_pkg::OP_FREE, 23'd1, '1);
		random_items(30);
		drain();

		write_reg(psa_pkg::CFG_HEAP_PAGES, 64'd0);
		send(psa_pkg::OP_INIT, 23'd1, '0);
		send(psa_pkg::OP_ALLOC, 23'd1, '0);
		send(psa_pkg::OP_FREE, 23'd1, '1);
		drain();

		write_reg(psa_pkg::CFG_HEAP_BASE, 64'h8000_0000_0000_0000);
		write_reg(psa_pkg::CFG_HEAP_PAGES, 64'd37);
		send(psa_pkg::OP_INIT, 23'd1, '0);
		random_items(100);
		drain();

		write_reg(psa_pkg::CFG_HEAP_BASE, '0);
		write_reg(psa_pkg::CFG_HEAP_PAGES, 64'd1024);
		send(psa_pkg::OP_INIT, 23'd1, '0);
		burst = 1;
		random_items(40);
		burst = 0;
		random_items(60);
		drain();
		repeat (50) @(posedge clk);

		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
